[hdl/smq_pkg.sv]
// Package for the sorted message queue: word types of both channels,
// operation codes and status codes.
// Depends on nothing; imported by the top level.
package smq_pkg;

    // Operation codes carried in the opcode field of an input word.
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_SORTED = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Status codes carried in a result word.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // One input word.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] entry_key;
        logic [7:0]  entry_handle;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  head_handle;
        logic [31:0] head_key;
        logic [4:0]  entry_count;
        logic        is_empty;
    } t_out_word;

endpackage

[hdl/smq_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; instanced by the sorted message queue.
module smq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/sorted_message_queue.sv]
// Sorted message queue: a bounded linked list of keyed entries in two RAMs.
// Depends on smq_pkg and smq_ram.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+-----------------------
//   in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_word)
//   out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out_word)
//
// A remove passes S_REM and S_EMIT; an append S_ALLOC, S_POP when a freed slot is
// reused, S_WRITE and S_EMIT; a sorted insert the same up to S_WRITE, then S_WALK
// over the entries passed, S_LINK and S_EMIT. A refused word or the unused opcode goes to S_EMIT.
// The walk reads one linked entry per cycle from the RAMs.
// Reset clears the state, head, tail, counts and output valid only; the RAMs need no clearing.
// The input stalls while a word is being worked on; a finished result sits in
// the output register, and only a following result waits for it to be taken.
module sorted_message_queue #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  smq_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output smq_pkg::t_out_word o_out_data
);

    import smq_pkg::*;

    localparam int SW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KW_IN = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int DW    = KEY_WIDTH + 8;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_LINK  = 3'd5;
    localparam logic [2:0] S_REM   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]           r_state, n_state;
    logic [1:0]           r_op, n_op;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [7:0]           r_handle, n_handle;
    logic [SW-1:0]        r_head, n_head;
    logic [SW-1:0]        r_tail, n_tail;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_fresh, n_fresh;
    logic [SW-1:0]        r_free_top, n_free_top;
    logic [SW-1:0]        r_slot, n_slot;
    logic [SW-1:0]        r_cur, n_cur;
    logic [SW-1:0]        r_prev, n_prev;
    logic                 r_has_prev, n_has_prev;
    logic [CW-1:0]        r_left, n_left;
    logic [1:0]           r_status, n_status;
    logic [KEY_WIDTH-1:0] r_res_key, n_res_key;
    logic [7:0]           r_res_handle, n_res_handle;
    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out_data, n_out_data;

    // RAM ports.
    logic [SW-1:0]        rd_addr;
    logic                 data_we;
    logic [DW-1:0]        data_rd;
    logic                 link_we;
    logic [SW-1:0]        link_wr_addr;
    logic [SW-1:0]        link_wr_data;
    logic [SW-1:0]        link_rd;

    logic [KEY_WIDTH-1:0] rd_key;
    logic [7:0]           rd_handle;
    logic                 walk_go;
    logic                 stack_busy;
    logic                 out_free;

    // Key and handle of each slot.
    smq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .i_clk     (i_clk),
        .i_wr_en   (data_we),
        .i_wr_addr (r_slot),
        .i_wr_data ({r_key, r_handle}),
        .i_rd_addr (rd_addr),
        .o_rd_data (data_rd)
    );

    // Next-slot link of each slot; freed slots form a stack through it.
    smq_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_we),
        .i_wr_addr (link_wr_addr),
        .i_wr_data (link_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (link_rd)
    );

    assign rd_key     = data_rd[DW-1:8];
    assign rd_handle  = data_rd[7:0];
    // The walk passes an entry whose key is not above the new key.
    assign walk_go    = (r_left != '0) && (r_key >= rd_key);
    // Freed slots wait on the stack whenever more slots were ever taken than are held.
    assign stack_busy = (r_fresh != r_count);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Shared read address of both RAMs.
    always_comb begin
        unique case (r_state)
            S_ALLOC: rd_addr = r_free_top;
            S_WALK:  rd_addr = link_rd;
            default: rd_addr = r_head;
        endcase
    end

    // RAM write control.
    always_comb begin
        data_we      = (r_state == S_WRITE);
        link_we      = 1'b0;
        link_wr_addr = r_slot;
        link_wr_data = r_cur;
        unique case (r_state)
            S_WRITE: begin
                link_we      = (r_op == OP_APPEND) && (r_count != '0);
                link_wr_addr = r_tail;
                link_wr_data = r_slot;
            end
            S_WALK: begin
                link_we      = !walk_go && r_has_prev;
                link_wr_addr = r_prev;
                link_wr_data = r_slot;
            end
            S_LINK: begin
                link_we      = (r_left != '0);
                link_wr_addr = r_slot;
                link_wr_data = r_cur;
            end
            S_REM: begin
                link_we      = 1'b1;
                link_wr_addr = r_head;
                link_wr_data = r_free_top;
            end
            default: begin
                link_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_handle     = r_handle;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_fresh      = r_fresh;
        n_free_top   = r_free_top;
        n_slot       = r_slot;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_has_prev   = r_has_prev;
        n_left       = r_left;
        n_status     = r_status;
        n_res_key    = r_res_key;
        n_res_handle = r_res_handle;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        // The output register empties when its word is taken.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = i_in_data.opcode;
                    n_key        = KEY_WIDTH'(i_in_data.entry_key[KW_IN-1:0]);
                    n_handle     = i_in_data.entry_handle;
                    n_status     = ST_OK;
                    n_res_key    = '0;
                    n_res_handle = '0;
                    n_state      = S_EMIT;
                    case (i_in_data.opcode)
                        OP_APPEND, OP_SORTED: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_REM;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                // Reuse a freed slot if there is one, else take a fresh slot.
                if (stack_busy) begin
                    n_slot  = r_free_top;
                    n_state = S_POP;
                end else begin
                    n_slot  = r_fresh[SW-1:0];
                    n_fresh = r_fresh + CW'(1);
                    n_state = S_WRITE;
                end
            end
            S_POP: begin
                n_free_top = link_rd;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                if (r_op == OP_APPEND) begin
                    if (r_count == '0) begin
                        n_head = r_slot;
                    end
                    n_tail  = r_slot;
                    n_count = r_count + CW'(1);
                    n_state = S_EMIT;
                end else begin
                    n_cur      = r_head;
                    n_left     = r_count;
                    n_has_prev = 1'b0;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_go) begin
                    n_prev     = r_cur;
                    n_has_prev = 1'b1;
                    n_cur      = link_rd;
                    n_left     = r_left - CW'(1);
                end else begin
                    if (!r_has_prev) begin
                        n_head = r_slot;
                    end
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                if (r_left == '0) begin
                    n_tail = r_slot;
                end
                n_count = r_count + CW'(1);
                n_state = S_EMIT;
            end
            S_REM: begin
                // Return the head entry and push its slot onto the free stack.
                n_res_key    = rd_key;
                n_res_handle = rd_handle;
                n_free_top   = r_head;
                n_count      = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end else begin
                    n_head = link_rd;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_data.status      = r_status;
                    n_out_data.head_handle = r_res_handle;
                    n_out_data.head_key    = 32'(r_res_key[KW_IN-1:0]);
                    n_out_data.entry_count = 5'(r_count);
                    n_out_data.is_empty    = (r_count == '0);
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers; reset clears the list control and the output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_key        <= n_key;
        r_handle     <= n_handle;
        r_free_top   <= n_free_top;
        r_slot       <= n_slot;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_has_prev   <= n_has_prev;
        r_left       <= n_left;
        r_status     <= n_status;
        r_res_key    <= n_res_key;
        r_res_handle <= n_res_handle;
        r_out_data   <= n_out_data;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[sim/sorted_message_queue_tb.sv]
`timescale 1ns / 1ps
// Testbench for sorted_message_queue: directed and random queue operations,
// each result word checked against a behavioural list model held here.
// Depends on smq_pkg and the sorted_message_queue RTL only.
module sorted_message_queue_tb;
    import smq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_CYCLES     = 40;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {
        STALL_NEVER,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_pattern;

    typedef struct packed {
        logic [31:0] key;
        logic [7:0]  handle;
    } t_queued_entry;

    logic      i_clk    = 1'b0;
    logic      i_rst_n  = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_data  = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_data;

    // Model of the queue contents, head first, and the results still owed.
    t_queued_entry held_entries[$];
    t_out_word     pending_results[$];
    int unsigned   failures = 0;
    int unsigned   burst_left = 0;
    int unsigned   hold_seq = 0;

    sorted_message_queue #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (32)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one operation to the list model and return the result it owes.
    function automatic t_out_word apply_queue_op(input t_in_word w);
        t_out_word     r;
        t_queued_entry e;
        int            pos;
        r = '0;
        r.status = ST_OK;
        case (w.opcode)
            OP_APPEND, OP_SORTED: begin
                if (held_entries.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    e.key = w.entry_key;
                    e.handle = w.entry_handle;
                    if (w.opcode == OP_APPEND) begin
                        held_entries.push_back(e);
                    end else begin
                        // Pass every entry whose key is not greater, so ties keep order.
                        pos = 0;
                        while (pos < held_entries.size() &&
                               held_entries[pos].key <= w.entry_key)
                            pos++;
                        held_entries.insert(pos, e);
                    end
                end
            end
            OP_REMOVE: begin
                if (held_entries.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    e = held_entries.pop_front();
                    r.head_handle = e.handle;
                    r.head_key = e.key;
                end
            end
            default: ;
        endcase
        r.entry_count = 5'(held_entries.size());
        r.is_empty = (held_entries.size() == 0);
        return r;
    endfunction

    function automatic t_in_word in_word(input logic [1:0] op, input logic [31:0] key,
                                         input logic [7:0] handle);
        t_in_word w;
        w.opcode = op;
        w.entry_key = key;
        w.entry_handle = handle;
        return w;
    endfunction

    // Random word; fill_bias favours inserts, otherwise removes dominate.
    function automatic t_in_word random_word(input bit fill_bias);
        t_in_word    w;
        int unsigned roll;
        w.entry_handle = 8'($urandom);
        case ($urandom_range(0, 3))
            0: w.entry_key = 32'($urandom_range(0, 7));
            1: w.entry_key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: w.entry_key = $urandom;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 3)
            w.opcode = OP_NONE;
        else if (roll < (fill_bias ? 70 : 32))
            w.opcode = ($urandom_range(0, 2) == 0) ? OP_APPEND : OP_SORTED;
        else
            w.opcode = OP_REMOVE;
        return w;
    endfunction

    // Offer one word and record its expected result once it is taken.
    task automatic send_word(input t_in_word w);
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge i_clk); while (in_stall);
        pending_results.push_back(apply_queue_op(w));
    endtask

    // Send within bursts of random length, with a random gap before each burst.
    task automatic paced_send(input t_in_word w);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_word(w);
    endtask

    // Stop offering until every owed result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Empty-queue cases, key and handle extremes, ties and the unused opcode.
    task automatic test_directed_ops();
        send_word(in_word(OP_REMOVE, 32'h0, 8'h00));
        send_word(in_word(OP_NONE, 32'hFFFF_FFFF, 8'hFF));
        send_word(in_word(OP_APPEND, 32'h0, 8'hFF));
        send_word(in_word(OP_APPEND, 32'hFFFF_FFFF, 8'h00));
        send_word(in_word(OP_SORTED, 32'h8000_0000, 8'h01));
        send_word(in_word(OP_SORTED, 32'h0, 8'h02));
        send_word(in_word(OP_SORTED, 32'hFFFF_FFFF, 8'h03));
        send_word(in_word(OP_SORTED, 32'h0, 8'h04));
        send_word(in_word(OP_APPEND, 32'h5, 8'h05));
        send_word(in_word(OP_SORTED, 32'h6, 8'h06));
        send_word(in_word(OP_NONE, 32'h0, 8'h00));
        repeat (10) send_word(in_word(OP_REMOVE, 32'hFFFF_FFFF, 8'hFF));
        drain_results();
    endtask

    // Fill to capacity, try both inserts while full, then empty and reuse.
    task automatic test_full_queue();
        t_in_word w;
        repeat (DEPTH) begin
            w = random_word(1'b1);
            w.opcode = $urandom_range(0, 1) ? OP_SORTED : OP_APPEND;
            paced_send(w);
        end
        paced_send(in_word(OP_APPEND, $urandom, 8'($urandom)));
        paced_send(in_word(OP_SORTED, $urandom, 8'($urandom)));
        paced_send(in_word(OP_NONE, $urandom, 8'($urandom)));
        repeat (DEPTH + 1) paced_send(in_word(OP_REMOVE, $urandom, 8'($urandom)));
        paced_send(in_word(OP_SORTED, 32'h10, 8'hA5));
        paced_send(in_word(OP_APPEND, 32'h1, 8'h5A));
        paced_send(in_word(OP_SORTED, 32'h8, 8'h3C));
        repeat (4) paced_send(in_word(OP_REMOVE, 32'h0, 8'h00));
        drain_results();
    endtask

    // Receiver holds off for a long stretch while words keep being offered.
    task automatic test_output_hold();
        hold_seq <= hold_seq + 1;
        repeat (40) send_word(random_word(1'b1));
        drain_results();
    endtask

    // Alternating fill and drain phases carry the count across its range.
    task automatic test_random_traffic();
        int unsigned count;
        for (int phase = 0; phase < 11; phase++) begin
            count = $urandom_range(120, 160);
            repeat (count) paced_send(random_word(phase[0] == 1'b0));
            if ($urandom_range(0, 2) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // Receiver stall pattern, changed every segment; a hold request overrides it.
    int unsigned    hold_seen = 0;
    int unsigned    hold_left = 0;
    int unsigned    segment_left = 0;
    t_stall_pattern stall_mode = STALL_NEVER;
    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            if (segment_left == 0) begin
                segment_left = $urandom_range(1, 60);
                stall_mode = t_stall_pattern'($urandom_range(0, 3));
            end
            segment_left--;
            case (stall_mode)
                STALL_NEVER: out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= ~out_stall;
            endcase
        end
    end

    // Compare each taken result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: result word with none expected: %p", $realtime, out_data);
            end else begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status ||
                    out_data.head_handle !== want.head_handle ||
                    out_data.head_key !== want.head_key ||
                    out_data.entry_count !== want.entry_count ||
                    out_data.is_empty !== want.is_empty) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $write("%0t: mismatch (expected/actual) status %0d/%0d ",
                               $realtime, want.status, out_data.status);
                        $display("handle %h/%h key %h/%h count %0d/%0d empty %b/%b",
                                 want.head_handle, out_data.head_handle,
                                 want.head_key, out_data.head_key,
                                 want.entry_count, out_data.entry_count,
                                 want.is_empty, out_data.is_empty);
                    end
                end
            end
        end
    end

    // Ends the run if no word moves on either channel for too long.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("sorted_message_queue_tb failed");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_ops();
        test_full_queue();
        test_output_hold();
        test_random_traffic();
        repeat (END_CYCLES) @(posedge i_clk);
        if (failures == 0)
            $display("sorted_message_queue_tb passed");
        else
            $display("sorted_message_queue_tb failed");
        $finish;
    end

endmodule
